[src/a2bd_pkg.sv]
// shared types and constants for the avcc to annex b demux
package a2bd_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   localparam logic [2:0] STEP_SC0  = 3'd0;
   localparam logic [2:0] STEP_SC3  = 3'd3;
   localparam logic [2:0] STEP_BYTE = 3'd4;
   localparam logic [2:0] STEP_TIME = 3'd5;

   localparam logic [7:0] START_LAST_BYTE = 8'h01;

   typedef struct packed {
      logic        has_start;
      logic        has_byte;
      logic        has_timing;
      logic [7:0]  data;
      logic [32:0] time_sum;
      logic [31:0] time_lat;
      logic        bad;
   } cmd_type;

endpackage

[src/avcc_to_annexb_demux.sv]
// top level: avcc to annex b converter with parser, command queue and emitter
// throughput per cycle: one byte in if the queue has room, one result out if not stalled
// a byte yields zero to six results, one per cycle from the queue head unless stalled
// the first result of a byte is registered in a queue entry, then in the output register
// input stall rises only when the four-entry command queue is full
// reset is synchronous; it clears parser state, queue pointers and the output valid
module avcc_to_annexb_demux #(
   parameter int POS_WIDTH = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_stream_byte,
   output logic [41:0] rsp_pres_time,
   output logic [41:0] rsp_decode_time,
   output logic        rsp_malformed,
   output logic        rsp_end_of_run
);
   import a2bd_pkg::*;

   logic    push, pop, head_valid, q_full;
   cmd_type push_cmd, head_cmd;

   a2bd_front #(
      .POS_WIDTH(POS_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .req_time_ms    (req_time_ms),
      .push           (push),
      .push_cmd       (push_cmd),
      .q_full         (q_full)
   );

   a2bd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .full       (q_full)
   );

   a2bd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_stream_byte (rsp_stream_byte),
      .rsp_pres_time   (rsp_pres_time),
      .rsp_decode_time (rsp_decode_time),
      .rsp_malformed   (rsp_malformed),
      .rsp_end_of_run  (rsp_end_of_run)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full) else $error("push into full queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("pop from empty queue");

   a_timing_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_end_of_run) else $error("timing record not last");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result valid after reset");

endmodule

[src/a2bd_front.sv]
// packet parser that turns each input byte into at most one emit command
module a2bd_front #(
   parameter int POS_WIDTH = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic [7:0]        req_data_byte,
   input  logic              req_first_byte,
   input  logic              req_last_byte,
   input  logic [31:0]       req_time_ms,
   output logic              push,
   output a2bd_pkg::cmd_type push_cmd,
   input  logic              q_full
);
   import a2bd_pkg::*;

   localparam logic [2:0] PH_HEAD    = 3'd0;
   localparam logic [2:0] PH_SPS     = 3'd1;
   localparam logic [2:0] PH_PPSCNT  = 3'd2;
   localparam logic [2:0] PH_PPSLEN  = 3'd3;
   localparam logic [2:0] PH_PPS     = 3'd4;
   localparam logic [2:0] PH_SEQDONE = 3'd5;
   localparam logic [2:0] PH_NALLEN  = 3'd6;
   localparam logic [2:0] PH_NAL     = 3'd7;

   logic [POS_WIDTH-1:0] pos_ff, pos_in, pos_sat;
   logic [2:0]           phase_ff, phase_in;
   logic [31:0]          acc_ff, acc_in;
   logic [31:0]          rem_ff, rem_in;
   logic                 keep_ff, keep_in;
   logic [23:0]          off_ff, off_in;
   logic [31:0]          tlat_ff, tlat_in;
   logic                 accept;
   cmd_type              cmd;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      pos_in   = req_first_byte ? '0 : pos_ff;
      phase_in = req_first_byte ? PH_HEAD : phase_ff;
      acc_in   = req_first_byte ? 32'd0 : acc_ff;
      rem_in   = req_first_byte ? 32'd0 : rem_ff;
      keep_in  = req_first_byte ? 1'b0 : keep_ff;
      off_in   = req_first_byte ? 24'd0 : off_ff;
      tlat_in  = req_first_byte ? req_time_ms : tlat_ff;
      pos_sat  = (pos_in == '1) ? pos_in : pos_in + 1'b1;
      cmd            = '0;
      cmd.data       = req_data_byte;
      case (phase_in)
         PH_HEAD: begin
            if (pos_in >= POS_WIDTH'(2) && pos_in <= POS_WIDTH'(4)) begin
               off_in = {off_in[15:0], req_data_byte};
            end
            if (req_op && pos_in >= POS_WIDTH'(4)) begin
               phase_in = PH_NALLEN;
               pos_in   = '0;
               acc_in   = 32'd0;
            end else if (!req_op && pos_in == POS_WIDTH'(11)) begin
               acc_in = {24'd0, req_data_byte};
               pos_in = pos_sat;
            end else if (!req_op && pos_in == POS_WIDTH'(12)) begin
               rem_in        = {16'd0, acc_in[7:0], req_data_byte};
               cmd.has_start = 1'b1;
               phase_in      = (rem_in != 32'd0) ? PH_SPS : PH_PPSCNT;
               pos_in        = '0;
            end else begin
               pos_in = pos_sat;
            end
         end
         PH_SPS: begin
            cmd.has_byte = 1'b1;
            rem_in       = rem_in - 32'd1;
            if (rem_in == 32'd0) begin
               phase_in = PH_PPSCNT;
            end
         end
         PH_PPSCNT: begin
            phase_in = PH_PPSLEN;
            pos_in   = '0;
         end
         PH_PPSLEN: begin
            if (pos_in == '0) begin
               acc_in = {24'd0, req_data_byte};
               pos_in = POS_WIDTH'(1);
            end else begin
               rem_in        = {16'd0, acc_in[7:0], req_data_byte};
               cmd.has_start = 1'b1;
               phase_in      = (rem_in != 32'd0) ? PH_PPS : PH_SEQDONE;
               pos_in        = '0;
            end
         end
         PH_PPS: begin
            cmd.has_byte = 1'b1;
            rem_in       = rem_in - 32'd1;
            if (rem_in == 32'd0) begin
               phase_in = PH_SEQDONE;
            end
         end
         PH_NALLEN: begin
            acc_in = {acc_in[23:0], req_data_byte};
            pos_in = pos_in + 1'b1;
            if (pos_in >= POS_WIDTH'(4)) begin
               pos_in = '0;
               if (acc_in != 32'd0) begin
                  rem_in   = acc_in;
                  phase_in = PH_NAL;
               end
               acc_in = 32'd0;
            end
         end
         PH_NAL: begin
            if (pos_in == '0) begin
               keep_in = (req_data_byte[4:0] == 5'd1) || (req_data_byte[4:0] == 5'd5);
               cmd.has_start = keep_in;
               pos_in = POS_WIDTH'(1);
            end
            cmd.has_byte = keep_in;
            rem_in = rem_in - 32'd1;
            if (rem_in == 32'd0) begin
               phase_in = PH_NALLEN;
               pos_in   = '0;
               acc_in   = 32'd0;
               keep_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
      if (req_last_byte) begin
         cmd.has_timing = 1'b1;
         cmd.time_sum   = {1'b0, tlat_in} + {9'd0, off_in};
         cmd.time_lat   = tlat_in;
         cmd.bad = !(phase_in == PH_SEQDONE || (phase_in == PH_NALLEN && pos_in == '0));
         pos_in   = '0;
         phase_in = PH_HEAD;
         acc_in   = 32'd0;
         rem_in   = 32'd0;
         keep_in  = 1'b0;
      end
   end

   assign push     = accept && (cmd.has_start || cmd.has_byte || cmd.has_timing);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PH_HEAD;
         acc_ff   <= 32'd0;
         rem_ff   <= 32'd0;
         keep_ff  <= 1'b0;
         off_ff   <= 24'd0;
         tlat_ff  <= 32'd0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         rem_ff   <= rem_in;
         keep_ff  <= keep_in;
         off_ff   <= off_in;
         tlat_ff  <= tlat_in;
      end
   end

endmodule

[src/a2bd_queue.sv]
// command queue between the parser and the emitter
module a2bd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  a2bd_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              head_valid,
   output a2bd_pkg::cmd_type head_cmd,
   output logic              full
);
   import a2bd_pkg::*;

   cmd_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/a2bd_back.sv]
// emitter that expands each command into result transfers
module a2bd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  a2bd_pkg::cmd_type head_cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [7:0]        rsp_stream_byte,
   output logic [41:0]       rsp_pres_time,
   output logic [41:0]       rsp_decode_time,
   output logic              rsp_malformed,
   output logic              rsp_end_of_run
);
   import a2bd_pkg::*;

   logic        started_ff, started_in;
   logic [2:0]  step_ff, step_in;
   logic [2:0]  first_step, cur_step, next_step;
   logic        is_last, load;
   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [41:0] pres_ff, pres_in;
   logic [41:0] dec_ff, dec_in;
   logic        bad_ff, bad_in;
   logic        eor_ff, eor_in;
   logic [41:0] sum_x, lat_x;

   always_comb begin
      if (head_cmd.has_start) begin
         first_step = STEP_SC0;
      end else if (head_cmd.has_byte) begin
         first_step = STEP_BYTE;
      end else begin
         first_step = STEP_TIME;
      end
      cur_step = started_ff ? step_ff : first_step;
      is_last  = (cur_step == STEP_TIME)
              || (cur_step == STEP_BYTE && !head_cmd.has_timing)
              || (cur_step == STEP_SC3 && !head_cmd.has_byte && !head_cmd.has_timing);
      case (cur_step)
         STEP_SC3:  next_step = head_cmd.has_byte ? STEP_BYTE : STEP_TIME;
         STEP_BYTE: next_step = STEP_TIME;
         default:   next_step = cur_step + 3'd1;
      endcase
   end

   assign load = head_valid && (!valid_ff || !rsp_stall);
   assign pop  = load && is_last;

   // times 1000 as 1024 - 16 - 8
   assign sum_x = {9'd0, head_cmd.time_sum};
   assign lat_x = {10'd0, head_cmd.time_lat};

   always_comb begin
      started_in = started_ff;
      step_in    = step_ff;
      valid_in   = valid_ff && rsp_stall;
      kind_in    = kind_ff;
      byte_in    = byte_ff;
      pres_in    = pres_ff;
      dec_in     = dec_ff;
      bad_in     = bad_ff;
      eor_in     = eor_ff;
      if (load) begin
         started_in = !is_last;
         step_in    = next_step;
         valid_in   = 1'b1;
         eor_in     = is_last;
         kind_in    = (cur_step == STEP_TIME);
         byte_in    = 8'd0;
         pres_in    = 42'd0;
         dec_in     = 42'd0;
         bad_in     = 1'b0;
         case (cur_step)
            STEP_SC3:  byte_in = START_LAST_BYTE;
            STEP_BYTE: byte_in = head_cmd.data;
            STEP_TIME: begin
               pres_in = (sum_x << 10) - (sum_x << 4) - (sum_x << 3);
               dec_in  = (lat_x << 10) - (lat_x << 4) - (lat_x << 3);
               bad_in  = head_cmd.bad;
            end
            default: byte_in = 8'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         step_ff    <= STEP_SC0;
         valid_ff   <= 1'b0;
      end else begin
         started_ff <= started_in;
         step_ff    <= step_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      pres_ff <= pres_in;
      dec_ff  <= dec_in;
      bad_ff  <= bad_in;
      eor_ff  <= eor_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_stream_byte = byte_ff;
   assign rsp_pres_time   = pres_ff;
   assign rsp_decode_time = dec_ff;
   assign rsp_malformed   = bad_ff;
   assign rsp_end_of_run  = eor_ff;

endmodule
